### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants shared by the postfix evaluator modules.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_DATA_WIDTH  = 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_OP   = 2'd1,
    CMD_END  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_NEG = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_NEGPOW    = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_BADDEPTH  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_READ,
    T_ALU
  } top_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_DFIX,
    A_PCHK,
    A_PSQ,
    A_DONE
  } alu_state_t;

  typedef enum logic [1:0] {
    MK_PLAIN,
    MK_RES,
    MK_SQ
  } mul_kind_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic    done;
    status_t err;
  } alu_rsp_t;

endpackage

### src/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix expression evaluator on a signed operand stack, one token a beat.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one token. in_tuser holds the command (push
// operand, apply operator, end of expression); in_tdata holds the operand and
// the operator code. Every accepted beat produces exactly one output beat with
// the status in out_tuser, the top of stack (or final result) in out_tdata and
// out_tlast set when the beat answers an end-of-expression token.
// Push, negate, end and any token after an error answer at once: the result
// is registered at the accept edge. Add and subtract go through a stack
// memory read, then the unit start and its done state, to the registered result.
// Multiply, divide and modulo run on the one-bit-a-cycle shift-add multiplier
// and restoring divider; multiply stops as soon as the multiplier is zero.
// Power runs square-and-multiply on the same multiplier, finishing sooner for
// small exponents.
// One token is in flight at a time; in_tready is low while it is worked on.
// Reset empties the stack and clears the sticky error. The stack memory is
// not cleared; entries are only read after being pushed. When the receiver
// stalls the result holds in the output register and no new token is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = pse_pkg::DEF_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] operand, [34:32] operator_code, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast   // done_res
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  pse_pkg::top_state_t state_r, state_nxt;
  pse_pkg::status_t    err_r, err_nxt;
  pse_pkg::status_t    ostat_r, ostat_nxt;
  pse_pkg::op_t        op_r, op_nxt;
  logic [PW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] tos_r, tos_nxt;
  logic          ovalid_r, ovalid_nxt, olast_r, olast_nxt;
  logic [31:0]   oval_r, oval_nxt;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [DW-1:0] mem_rd_data;

  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;
  logic [DW-1:0]     alu_result;

  // Operand is sign-extended then wrapped to the stack width.
  logic [DW-1:0] opnd_dw;
  logic [DW-1:0] neg_tos;
  logic [31:0]   tos_vis, cur_vis;
  pse_pkg::cmd_t cmd;
  logic          accept;

  assign opnd_dw = DW'(64'(signed'(in_tdata[31:0])));
  assign neg_tos = -tos_r;
  assign tos_vis = 32'(64'(tos_r));
  assign cur_vis = (depth_r != '0) ? tos_vis : '0;
  assign cmd     = pse_pkg::cmd_t'(in_tuser);

  // A token is taken only when the output register is free at this edge.
  assign in_tready  = (state_r == pse_pkg::T_IDLE) && (!ovalid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

  pse_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (tos_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  pse_alu #(
    .DATA_WIDTH (DW)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a      (mem_rd_data),
    .b      (tos_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pse_pkg::T_IDLE;
      err_r    <= pse_pkg::ST_OK;
      depth_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      err_r    <= err_nxt;
      depth_r  <= depth_nxt;
      ovalid_r <= ovalid_nxt;
    end
    tos_r   <= tos_nxt;
    op_r    <= op_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  // The register file keeps the top of stack in tos_r; the memory holds the
  // entries below it, so entry depth-2 is the left operand of a binary op.
  always_comb begin
    state_nxt   = state_r;
    err_nxt     = err_r;
    depth_nxt   = depth_r;
    tos_nxt     = tos_r;
    op_nxt      = op_r;
    oval_nxt    = oval_r;
    ostat_nxt   = ostat_r;
    olast_nxt   = olast_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(depth_r - PW'(1));
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(depth_r - PW'(2));
    alu_req.start = 1'b0;
    alu_req.op    = op_r;

    unique case (state_r)
      pse_pkg::T_IDLE: begin
        if (accept) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b0;
          ostat_nxt  = err_r;
          oval_nxt   = cur_vis;
          op_nxt     = pse_pkg::op_t'(in_tdata[34:32]);
          if (cmd == pse_pkg::CMD_END) begin
            olast_nxt = 1'b1;
            depth_nxt = '0;
            err_nxt   = pse_pkg::ST_OK;
            if (err_r == pse_pkg::ST_OK && depth_r != PW'(1)) begin
              ostat_nxt = pse_pkg::ST_BADDEPTH;
              oval_nxt  = '0;
            end else if (err_r != pse_pkg::ST_OK) begin
              oval_nxt = '0;
            end else begin
              oval_nxt = tos_vis;
            end
          end else if (err_r == pse_pkg::ST_OK) begin
            case (cmd)
              pse_pkg::CMD_PUSH: begin
                if (depth_r == PW'(STACK_DEPTH)) begin
                  err_nxt   = pse_pkg::ST_OVERFLOW;
                  ostat_nxt = pse_pkg::ST_OVERFLOW;
                end else begin
                  mem_wr_en = (depth_r != '0);
                  tos_nxt   = opnd_dw;
                  depth_nxt = depth_r + PW'(1);
                  oval_nxt  = 32'(64'(opnd_dw));
                end
              end
              pse_pkg::CMD_OP: begin
                if (in_tdata[34:32] == pse_pkg::OP_NEG) begin
                  if (depth_r == '0) begin
                    err_nxt   = pse_pkg::ST_UNDERFLOW;
                    ostat_nxt = pse_pkg::ST_UNDERFLOW;
                  end else begin
                    tos_nxt  = neg_tos;
                    oval_nxt = 32'(64'(neg_tos));
                  end
                end else if (in_tdata[34:32] > pse_pkg::OP_NEG) begin
                  // Unused operator code: no change.
                end else if (depth_r < PW'(2)) begin
                  err_nxt   = pse_pkg::ST_UNDERFLOW;
                  ostat_nxt = pse_pkg::ST_UNDERFLOW;
                end else begin
                  mem_rd_en  = 1'b1;
                  ovalid_nxt = 1'b0;
                  state_nxt  = pse_pkg::T_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      pse_pkg::T_READ: begin
        alu_req.start = 1'b1;
        state_nxt     = pse_pkg::T_ALU;
      end
      pse_pkg::T_ALU: begin
        if (alu_rsp.done) begin
          ovalid_nxt = 1'b1;
          olast_nxt  = 1'b0;
          state_nxt  = pse_pkg::T_IDLE;
          if (alu_rsp.err != pse_pkg::ST_OK) begin
            err_nxt   = alu_rsp.err;
            ostat_nxt = alu_rsp.err;
            oval_nxt  = tos_vis;
          end else begin
            tos_nxt   = alu_result;
            depth_nxt = depth_r - PW'(1);
            ostat_nxt = pse_pkg::ST_OK;
            oval_nxt  = 32'(64'(alu_result));
          end
        end
      end
      default: begin
        state_nxt = pse_pkg::T_IDLE;
      end
    endcase
  end

  `PSE_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= PW'(STACK_DEPTH), "stack depth out of range")
  `PSE_ASSERT_NOW(a_alu_done_wait, alu_rsp.done, state_r == pse_pkg::T_ALU,
                  "unit finished with no operation pending")
  `PSE_ASSERT_NEXT(a_end_clears, accept && cmd == pse_pkg::CMD_END,
                   depth_r == '0 && err_r == pse_pkg::ST_OK && out_tlast,
                   "end token did not clear the stack")
  `PSE_ASSERT_NOW(a_no_overwrite, state_r == pse_pkg::T_ALU && alu_rsp.done, !ovalid_r,
                  "result would overwrite an unsent beat")

endmodule

### src/pse_stack_mem.sv
// ----------------------------------------------------------------------------
// pse_stack_mem
// Single-port-write, single-port-read stack storage with registered read.
// ----------------------------------------------------------------------------
module pse_stack_mem #(
  parameter int DEPTH = pse_pkg::DEF_STACK_DEPTH,
  parameter int WIDTH = pse_pkg::DEF_DATA_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// Iterative arithmetic unit: add and subtract, one shift-add multiplier and one
// restoring divider step, sequenced for mul, div, mod and square-and-multiply power.
// ----------------------------------------------------------------------------
module pse_alu #(
  parameter int DATA_WIDTH = pse_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pse_pkg::alu_req_t     req,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output pse_pkg::alu_rsp_t     rsp,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DW + 1);

  pse_pkg::alu_state_t state_r, state_nxt;
  pse_pkg::mul_kind_t  kind_r, kind_nxt;
  pse_pkg::op_t        op_r, op_nxt;
  pse_pkg::status_t    err_r, err_nxt;
  logic [DW-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt, mplier_r, mplier_nxt;
  logic [DW-1:0] res_r, res_nxt, base_r, base_nxt, exp_r, exp_nxt;
  logic [DW-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          negq_r, negq_nxt, negr_r, negr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pse_pkg::A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r   <= kind_nxt;
    op_r     <= op_nxt;
    err_r    <= err_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    res_r    <= res_nxt;
    base_r   <= base_nxt;
    exp_r    <= exp_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    negq_r   <= negq_nxt;
    negr_r   <= negr_nxt;
  end

  always_comb begin
    logic [DW:0] trial;
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    op_nxt     = op_r;
    err_nxt    = err_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    res_nxt    = res_r;
    base_nxt   = base_r;
    exp_nxt    = exp_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    negq_nxt   = negq_r;
    negr_nxt   = negr_r;
    trial      = {rem_r, quo_r[DW-1]};
    rsp.done   = 1'b0;
    rsp.err    = err_r;
    result     = res_r;

    unique case (state_r)
      pse_pkg::A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          err_nxt = pse_pkg::ST_OK;
          case (req.op)
            pse_pkg::OP_ADD: begin
              res_nxt   = a + b;
              state_nxt = pse_pkg::A_DONE;
            end
            pse_pkg::OP_SUB: begin
              res_nxt   = a - b;
              state_nxt = pse_pkg::A_DONE;
            end
            pse_pkg::OP_MUL: begin
              acc_nxt    = '0;
              mcand_nxt  = a;
              mplier_nxt = b;
              kind_nxt   = pse_pkg::MK_PLAIN;
              state_nxt  = pse_pkg::A_MUL;
            end
            pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
              if (b == '0) begin
                err_nxt   = pse_pkg::ST_DIVZERO;
                state_nxt = pse_pkg::A_DONE;
              end else begin
                quo_nxt   = a[DW-1] ? -a : a;
                dvs_nxt   = b[DW-1] ? -b : b;
                rem_nxt   = '0;
                cnt_nxt   = CW'(DW);
                negq_nxt  = a[DW-1] ^ b[DW-1];
                negr_nxt  = a[DW-1];
                state_nxt = pse_pkg::A_DIV;
              end
            end
            pse_pkg::OP_POW: begin
              if (b[DW-1]) begin
                // Negative exponent: only bases of one, minus one and zero matter.
                state_nxt = pse_pkg::A_DONE;
                if (a == '0) begin
                  err_nxt = pse_pkg::ST_NEGPOW;
                end else if (a == DW'(1)) begin
                  res_nxt = DW'(1);
                end else if (a == '1) begin
                  res_nxt = b[0] ? '1 : DW'(1);
                end else begin
                  res_nxt = '0;
                end
              end else begin
                res_nxt   = DW'(1);
                base_nxt  = a;
                exp_nxt   = b;
                state_nxt = pse_pkg::A_PCHK;
              end
            end
            default: begin
              state_nxt = pse_pkg::A_DONE;
            end
          endcase
        end
      end
      pse_pkg::A_MUL: begin
        if (mplier_r == '0) begin
          case (kind_r)
            pse_pkg::MK_RES: begin
              res_nxt   = acc_r;
              exp_nxt   = exp_r >> 1;
              state_nxt = pse_pkg::A_PSQ;
            end
            pse_pkg::MK_SQ: begin
              base_nxt  = acc_r;
              state_nxt = pse_pkg::A_PCHK;
            end
            default: begin
              res_nxt   = acc_r;
              state_nxt = pse_pkg::A_DONE;
            end
          endcase
        end else begin
          acc_nxt    = mplier_r[0] ? acc_r + mcand_r : acc_r;
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      pse_pkg::A_DIV: begin
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = DW'(trial - {1'b0, dvs_r});
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = pse_pkg::A_DFIX;
        end
      end
      pse_pkg::A_DFIX: begin
        if (op_r == pse_pkg::OP_DIV) begin
          res_nxt = negq_r ? -quo_r : quo_r;
        end else begin
          res_nxt = negr_r ? -rem_r : rem_r;
        end
        state_nxt = pse_pkg::A_DONE;
      end
      pse_pkg::A_PCHK: begin
        if (exp_r == '0) begin
          state_nxt = pse_pkg::A_DONE;
        end else if (exp_r[0]) begin
          acc_nxt    = '0;
          mcand_nxt  = base_r;
          mplier_nxt = res_r;
          kind_nxt   = pse_pkg::MK_RES;
          state_nxt  = pse_pkg::A_MUL;
        end else begin
          exp_nxt   = exp_r >> 1;
          state_nxt = pse_pkg::A_PSQ;
        end
      end
      pse_pkg::A_PSQ: begin
        if (exp_r == '0) begin
          state_nxt = pse_pkg::A_DONE;
        end else begin
          acc_nxt    = '0;
          mcand_nxt  = base_r;
          mplier_nxt = base_r;
          kind_nxt   = pse_pkg::MK_SQ;
          state_nxt  = pse_pkg::A_MUL;
        end
      end
      pse_pkg::A_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = pse_pkg::A_IDLE;
      end
      default: begin
        state_nxt = pse_pkg::A_IDLE;
      end
    endcase
  end

endmodule
